FILE: rtl/lmt_pkg.sv
// Package for the lease membership table: shared types, codes and the
// controller-to-datapath command and status structures. No dependencies.
package lmt_pkg;

    // Command codes carried in the input tuser.
    typedef enum logic [2:0] {
        CMD_RESERVE = 3'd0,
        CMD_ACK     = 3'd1,
        CMD_ABORT   = 3'd2,
        CMD_FAILURE = 3'd3,
        CMD_SUCCESS = 3'd4,
        CMD_TICK    = 3'd5,
        CMD_READ    = 3'd6,
        CMD_INVALID = 3'd7
    } cmd_t;

    // Slot states.
    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_RESERVED = 2'd1,
        SLOT_ACTIVE   = 2'd2,
        SLOT_SUSPECT  = 2'd3
    } slot_state_t;

    // Result status codes.
    typedef enum logic [1:0] {
        RESP_OK      = 2'd0,
        RESP_INVALID = 2'd1,
        RESP_NOSPACE = 2'd2,
        RESP_BUSY    = 2'd3
    } resp_t;

    // Register indexes on the configuration port.
    localparam logic REG_SESSION = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RES_WR,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_OP_RD,
        ST_OP_CHK,
        ST_FIN
    } ctrl_state_t;

    // Slot address register operations.
    typedef enum logic [1:0] {
        ADDR_HOLD,
        ADDR_ZERO,
        ADDR_NODE,
        ADDR_INC
    } addr_op_t;

    // Datapath actions, one per cycle.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INIT,
        ACT_SCAN,
        ACT_RESV,
        ACT_TICK,
        ACT_OP
    } act_t;

    // One stored slot entry.
    typedef struct packed {
        logic [63:0] device;
        logic [15:0] lease;
        logic [63:0] reserve_time;
        logic [63:0] success_time;
        logic [63:0] suspect_time;
    } entry_t;

    typedef struct packed {
        logic     load;
        addr_op_t addr_op;
        act_t     act;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic pre_invalid;
        logic tick_en;
        logic last;
        logic hit;
        logic out_busy;
    } dp_sts_t;

endpackage

FILE: rtl/lmt_ctrl.sv
// Controller state machine for the lease membership table.
// Depends on lmt_pkg; drives lmt_dp through command and status structs.
module lmt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lmt_pkg::dp_sts_t sts,
    output lmt_pkg::dp_cmd_t cmd
);

    lmt_pkg::ctrl_state_t state_reg;
    lmt_pkg::ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lmt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = lmt_pkg::ST_DECODE;
                end
            end
            lmt_pkg::ST_DECODE:
            begin
                if (sts.pre_invalid)
                begin
                    state_next = lmt_pkg::ST_FIN;
                end
                else if (sts.cmd == lmt_pkg::CMD_RESERVE)
                begin
                    state_next = lmt_pkg::ST_SCAN_RD;
                end
                else if (sts.cmd == lmt_pkg::CMD_TICK)
                begin
                    state_next = sts.tick_en ? lmt_pkg::ST_TICK_RD : lmt_pkg::ST_FIN;
                end
                else
                begin
                    state_next = lmt_pkg::ST_OP_RD;
                end
            end
            lmt_pkg::ST_SCAN_RD:  state_next = lmt_pkg::ST_SCAN_CHK;
            lmt_pkg::ST_SCAN_CHK:
            begin
                if (sts.hit)
                begin
                    state_next = lmt_pkg::ST_FIN;
                end
                else if (sts.last)
                begin
                    state_next = lmt_pkg::ST_RES_WR;
                end
                else
                begin
                    state_next = lmt_pkg::ST_SCAN_RD;
                end
            end
            lmt_pkg::ST_RES_WR:   state_next = lmt_pkg::ST_FIN;
            lmt_pkg::ST_TICK_RD:  state_next = lmt_pkg::ST_TICK_CHK;
            lmt_pkg::ST_TICK_CHK:
            begin
                state_next = sts.last ? lmt_pkg::ST_FIN : lmt_pkg::ST_TICK_RD;
            end
            lmt_pkg::ST_OP_RD:    state_next = lmt_pkg::ST_OP_CHK;
            lmt_pkg::ST_OP_CHK:   state_next = lmt_pkg::ST_FIN;
            lmt_pkg::ST_FIN:
            begin
                if (!sts.out_busy)
                begin
                    state_next = lmt_pkg::ST_IDLE;
                end
            end
            default:              state_next = lmt_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd.load     = 1'b0;
        cmd.addr_op  = lmt_pkg::ADDR_HOLD;
        cmd.act      = lmt_pkg::ACT_NONE;
        cmd.out_load = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            lmt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            lmt_pkg::ST_DECODE:
            begin
                cmd.act = lmt_pkg::ACT_INIT;
                if (sts.cmd == lmt_pkg::CMD_RESERVE || sts.cmd == lmt_pkg::CMD_TICK)
                begin
                    cmd.addr_op = lmt_pkg::ADDR_ZERO;
                end
                else
                begin
                    cmd.addr_op = lmt_pkg::ADDR_NODE;
                end
            end
            lmt_pkg::ST_SCAN_CHK:
            begin
                cmd.act = lmt_pkg::ACT_SCAN;
                if (!sts.hit)
                begin
                    cmd.addr_op = sts.last ? lmt_pkg::ADDR_NODE : lmt_pkg::ADDR_INC;
                end
            end
            lmt_pkg::ST_RES_WR:   cmd.act = lmt_pkg::ACT_RESV;
            lmt_pkg::ST_TICK_CHK:
            begin
                cmd.act = lmt_pkg::ACT_TICK;
                if (!sts.last)
                begin
                    cmd.addr_op = lmt_pkg::ADDR_INC;
                end
            end
            lmt_pkg::ST_OP_CHK:   cmd.act = lmt_pkg::ACT_OP;
            lmt_pkg::ST_FIN:      cmd.out_load = !sts.out_busy;
            default:
            begin
                cmd.act = lmt_pkg::ACT_NONE;
            end
        endcase
    end

endmodule

FILE: rtl/lmt_dp.sv
// Datapath of the lease membership table: input latch, slot memory, state
// flops, counters and result register. Depends on lmt_pkg; driven by lmt_ctrl.
module lmt_dp #(
    parameter int PEER_COUNT = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [151:0]     s_tdata,
    input  logic [2:0]       s_tuser,
    input  logic [31:0]      session_id,
    input  logic [31:0]      lease_timeout,
    input  lmt_pkg::dp_cmd_t cmd,
    output lmt_pkg::dp_sts_t sts,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [295:0]     m_tdata
);

    localparam int IW = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;
    localparam int CW = $clog2(PEER_COUNT + 1);

    // Latched input transaction.
    lmt_pkg::cmd_t cmd_reg;
    logic [63:0]   key_reg;
    logic [7:0]    node_reg;
    logic [15:0]   lease_reg;
    logic [63:0]   now_reg;

    // Slot storage.
    lmt_pkg::entry_t     mem [PEER_COUNT];
    lmt_pkg::entry_t     rd_q;
    logic [1:0]          state_reg [PEER_COUNT];
    logic [IW-1:0]       addr_reg;
    logic [CW-1:0]       live_reg, sus_reg, free_reg;

    // Result being built.
    lmt_pkg::resp_t      res_status_reg;
    logic [7:0]          granted_reg;
    logic [1:0]          rd_state_reg;
    lmt_pkg::entry_t     rd_entry_reg;

    logic [295:0]        out_data_reg;
    logic                out_valid_reg;

    lmt_pkg::slot_state_t st;
    logic                 node_ok;
    logic [IW-1:0]        node_idx;
    logic [63:0]          ref_time;
    logic                 expire;
    logic                 hit;
    logic                 st_we;
    lmt_pkg::slot_state_t st_wval;
    logic                 mem_we;
    lmt_pkg::entry_t      mem_wdata;
    logic live_inc, live_dec, sus_inc, sus_dec, free_inc, free_dec;
    logic                 set_status;
    lmt_pkg::resp_t       new_status;
    logic                 pre_invalid;

    assign st       = lmt_pkg::slot_state_t'(state_reg[addr_reg]);
    assign node_ok  = (node_reg >= 8'd1) && (node_reg <= 8'(PEER_COUNT));
    assign node_idx = IW'(node_reg - 8'd1);
    assign hit      = (st != lmt_pkg::SLOT_FREE) && (rd_q.device == key_reg);

    // Requests rejected before any slot is looked at.
    always_comb
    begin
        unique case (cmd_reg)
            lmt_pkg::CMD_RESERVE:
                pre_invalid = (session_id == 32'd0) || (lease_timeout == 32'd0) ||
                              (key_reg == 64'd0) || !node_ok || (lease_reg == 16'd0);
            lmt_pkg::CMD_TICK:    pre_invalid = 1'b0;
            lmt_pkg::CMD_INVALID: pre_invalid = 1'b1;
            default:              pre_invalid = !node_ok;
        endcase
    end

    // Reference time for expiry.
    always_comb
    begin
        unique case (st)
            lmt_pkg::SLOT_RESERVED: ref_time = rd_q.reserve_time;
            lmt_pkg::SLOT_ACTIVE:   ref_time = rd_q.success_time;
            lmt_pkg::SLOT_SUSPECT:  ref_time = rd_q.suspect_time;
            default:                ref_time = 64'd0;
        endcase
    end

    assign expire = (st != lmt_pkg::SLOT_FREE) && (now_reg >= ref_time) &&
                    ((now_reg - ref_time) >= {32'd0, lease_timeout});

    assign sts.cmd         = cmd_reg;
    assign sts.pre_invalid = pre_invalid;
    assign sts.tick_en     = (lease_timeout != 32'd0);
    assign sts.last        = (addr_reg == IW'(PEER_COUNT - 1));
    assign sts.hit         = hit;
    assign sts.out_busy    = out_valid_reg && !m_tready;

    // Per-slot actions: state, memory and counter updates.
    always_comb
    begin
        st_we      = 1'b0;
        st_wval    = lmt_pkg::SLOT_FREE;
        mem_we     = 1'b0;
        mem_wdata  = rd_q;
        live_inc   = 1'b0;
        live_dec   = 1'b0;
        sus_inc    = 1'b0;
        sus_dec    = 1'b0;
        free_inc   = 1'b0;
        free_dec   = 1'b0;
        set_status = 1'b0;
        new_status = lmt_pkg::RESP_OK;
        unique case (cmd.act)
            lmt_pkg::ACT_RESV:
            begin
                set_status = 1'b1;
                if (live_reg >= CW'(PEER_COUNT))
                begin
                    new_status = lmt_pkg::RESP_NOSPACE;
                end
                else if (st != lmt_pkg::SLOT_FREE)
                begin
                    new_status = lmt_pkg::RESP_BUSY;
                end
                else
                begin
                    st_we                  = 1'b1;
                    st_wval                = lmt_pkg::SLOT_RESERVED;
                    mem_we                 = 1'b1;
                    mem_wdata.device       = key_reg;
                    mem_wdata.lease        = lease_reg;
                    mem_wdata.reserve_time = now_reg;
                    mem_wdata.success_time = 64'd0;
                    mem_wdata.suspect_time = 64'd0;
                    free_dec               = 1'b1;
                end
            end
            lmt_pkg::ACT_TICK:
            begin
                if (expire)
                begin
                    st_we    = 1'b1;
                    free_inc = 1'b1;
                    live_dec = (st == lmt_pkg::SLOT_ACTIVE) || (st == lmt_pkg::SLOT_SUSPECT);
                    sus_dec  = (st == lmt_pkg::SLOT_SUSPECT);
                end
            end
            lmt_pkg::ACT_OP:
            begin
                unique case (cmd_reg)
                    lmt_pkg::CMD_ACK:
                    begin
                        if (st == lmt_pkg::SLOT_RESERVED)
                        begin
                            st_we                  = 1'b1;
                            st_wval                = lmt_pkg::SLOT_ACTIVE;
                            mem_we                 = 1'b1;
                            mem_wdata.success_time = now_reg;
                            mem_wdata.suspect_time = 64'd0;
                            live_inc               = 1'b1;
                        end
                        else
                        begin
                            set_status = 1'b1;
                            new_status = lmt_pkg::RESP_INVALID;
                        end
                    end
                    lmt_pkg::CMD_ABORT:
                    begin
                        if (st == lmt_pkg::SLOT_RESERVED)
                        begin
                            st_we    = 1'b1;
                            free_inc = 1'b1;
                        end
                        else
                        begin
                            set_status = 1'b1;
                            new_status = lmt_pkg::RESP_INVALID;
                        end
                    end
                    lmt_pkg::CMD_FAILURE:
                    begin
                        if (st == lmt_pkg::SLOT_ACTIVE)
                        begin
                            st_we                  = 1'b1;
                            st_wval                = lmt_pkg::SLOT_SUSPECT;
                            mem_we                 = 1'b1;
                            mem_wdata.suspect_time = now_reg;
                            sus_inc                = 1'b1;
                        end
                        else if (st != lmt_pkg::SLOT_SUSPECT)
                        begin
                            set_status = 1'b1;
                            new_status = lmt_pkg::RESP_INVALID;
                        end
                    end
                    lmt_pkg::CMD_SUCCESS:
                    begin
                        if (st == lmt_pkg::SLOT_ACTIVE || st == lmt_pkg::SLOT_SUSPECT)
                        begin
                            st_we                  = 1'b1;
                            st_wval                = lmt_pkg::SLOT_ACTIVE;
                            mem_we                 = 1'b1;
                            mem_wdata.success_time = now_reg;
                            mem_wdata.suspect_time = 64'd0;
                            sus_dec                = (st == lmt_pkg::SLOT_SUSPECT);
                        end
                        else
                        begin
                            set_status = 1'b1;
                            new_status = lmt_pkg::RESP_INVALID;
                        end
                    end
                    default:
                    begin
                        set_status = 1'b0;
                    end
                endcase
            end
            default:
            begin
                set_status = 1'b0;
            end
        endcase
    end

    // Input latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= lmt_pkg::cmd_t'(s_tuser);
            key_reg   <= s_tdata[63:0];
            node_reg  <= s_tdata[71:64];
            lease_reg <= s_tdata[87:72];
            now_reg   <= s_tdata[151:88];
        end
    end

    // Slot memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        rd_q <= mem[addr_reg];
    end

    // Slot states, address and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PEER_COUNT; i++)
            begin
                state_reg[i] <= lmt_pkg::SLOT_FREE;
            end
            addr_reg <= '0;
            live_reg <= '0;
            sus_reg  <= '0;
            free_reg <= CW'(PEER_COUNT);
        end
        else
        begin
            if (st_we)
            begin
                state_reg[addr_reg] <= st_wval;
            end
            unique case (cmd.addr_op)
                lmt_pkg::ADDR_ZERO: addr_reg <= '0;
                lmt_pkg::ADDR_NODE: addr_reg <= node_idx;
                lmt_pkg::ADDR_INC:  addr_reg <= addr_reg + IW'(1);
                default:            addr_reg <= addr_reg;
            endcase
            live_reg <= live_reg + CW'(live_inc) - CW'(live_dec);
            sus_reg  <= sus_reg + CW'(sus_inc) - CW'(sus_dec);
            free_reg <= free_reg + CW'(free_inc) - CW'(free_dec);
        end
    end

    // Result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.act == lmt_pkg::ACT_INIT)
        begin
            res_status_reg <= pre_invalid ? lmt_pkg::RESP_INVALID : lmt_pkg::RESP_OK;
            granted_reg    <= 8'd0;
            rd_state_reg   <= lmt_pkg::SLOT_FREE;
            rd_entry_reg   <= '0;
        end
        else
        begin
            if (set_status)
            begin
                res_status_reg <= new_status;
            end
            if (cmd.act == lmt_pkg::ACT_SCAN && hit)
            begin
                granted_reg <= 8'(addr_reg) + 8'd1;
            end
            if (cmd.act == lmt_pkg::ACT_RESV && new_status == lmt_pkg::RESP_OK)
            begin
                granted_reg <= node_reg;
            end
            if (cmd.act == lmt_pkg::ACT_OP && cmd_reg == lmt_pkg::CMD_READ &&
                st != lmt_pkg::SLOT_FREE)
            begin
                rd_state_reg <= st;
                rd_entry_reg <= rd_q;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {4'(free_reg), 4'(sus_reg), 4'(live_reg),
                             rd_entry_reg.suspect_time, rd_entry_reg.success_time,
                             rd_entry_reg.reserve_time, rd_entry_reg.lease,
                             rd_entry_reg.device, rd_state_reg, granted_reg,
                             res_status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/lease_membership_table_top.sv
// Top level of the lease membership table: configuration port, controller
// and datapath. Depends on lmt_pkg, lmt_ctrl and lmt_dp.
//
// One command is taken at a time. Reserve and tick both walk the slot
// memory one slot after another (address, then registered read); reserve
// stops early when the device is already held by a slot, and tick is
// skipped with a zero lease timeout. The other commands look at one slot,
// and a command rejected on its fields alone looks at none. A command
// takes longer while a previous result still waits in the output register.
// A finished result waits in the output register while the next command
// is being worked on.
module lease_membership_table_top #(
    parameter int PEER_COUNT = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    // APB-style configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Command stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,   // device_key, node_number, lease_number, now_time
    input  logic [2:0]   s_tuser,   // command
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [295:0] m_tdata    // status, granted_node, slot_status, slot_device,
                                    // slot_lease, slot_reserve_time, slot_success_time,
                                    // slot_suspect_time, active_total, suspect_total,
                                    // free_total
);

    logic [31:0] session_reg;
    logic [31:0] timeout_reg;
    lmt_pkg::dp_cmd_t dp_cmd;
    lmt_pkg::dp_sts_t dp_sts;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg <= 32'd0;
            timeout_reg <= 32'd0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == lmt_pkg::REG_SESSION)
            begin
                session_reg <= pwdata;
            end
            else
            begin
                timeout_reg <= pwdata;
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lmt_pkg::REG_TIMEOUT) ? timeout_reg : session_reg;

    lmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    lmt_dp #(
        .PEER_COUNT (PEER_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .session_id    (session_reg),
        .lease_timeout (timeout_reg),
        .cmd           (dp_cmd),
        .sts           (dp_sts),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

FILE: rtl/lmt_checker.sv
// Port-level checks for the lease membership table top level, and the bind
// that attaches them. Depends on lease_membership_table_top.
module lmt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [295:0] m_tdata
);

    // A stalled result transaction keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // A granted node only comes with an ok status.
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[9:2] != 8'd0) |-> (m_tdata[1:0] == 2'd0))
        else $error("granted node with a failing status");

    // Slot contents are reported only with an ok status.
    a_slot_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11:10] != 2'd0) |-> (m_tdata[1:0] == 2'd0))
        else $error("slot contents with a failing status");

    // The block never accepts two commands on successive edges.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while one is in progress");

endmodule

bind lease_membership_table_top lmt_checker u_lmt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
